>>> hdl/task_metric_table_macros.svh
// Assertion macros for the task metric table RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef TASK_METRIC_TABLE_MACROS_SVH
`define TASK_METRIC_TABLE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define TMT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("task metric table check failed");
// Next-cycle implication, disabled during reset
`define TMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("task metric table check failed");
`else
`define TMT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TMT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/tmt_pkg.sv
// Shared types and constants for the task metric table.
// No dependencies; imported by tmt_ram users and the top level.
package tmt_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] task_key;
        logic [31:0] run_time;
        logic [31:0] stack_high_mark;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] total_time;
        logic [31:0] run_count;
        logic [31:0] stack_peak;
    } t_out_item;

    typedef struct packed {
        logic [63:0] total_time;
        logic [31:0] run_count;
        logic [31:0] stack_peak;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE,
        S_RESPOND
    } t_state;

endpackage

>>> hdl/task_metric_table.sv
// Task metric table: key RAM scanned one entry per cycle, metrics RAM updated read-modify-write.
// For records and gets the key scan sets how long a result takes; clear and unused commands skip
// the scan. Items go one at a time: no new item is accepted until the result of the last has
// entered the output register, which waits while that register is held.
// Reset (synchronous, i_rst_n low) empties the table and drops any pending result; RAMs are not cleared.
// Depends on tmt_pkg, tmt_ram and task_metric_table_macros.svh.
`include "task_metric_table_macros.svh"

module task_metric_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tmt_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tmt_pkg::t_out_item o_out_data
);
    import tmt_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_cmp_v, n_cmp_v;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0] r_slot, n_slot;
    t_in_item         r_item, n_item;
    t_out_item        r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             key_we;
    logic [IDX_W-1:0] key_waddr;
    logic [31:0]      key_wdata;
    logic [31:0]      key_rdata;
    logic             data_we;
    logic [IDX_W-1:0] data_waddr;
    t_entry           data_wdata;
    logic [ENTRY_W-1:0] data_rdata_raw;
    t_entry           data_rdata;

    logic             hit;
    logic             miss;
    logic             full;

    tmt_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (key_rdata)
    );

    tmt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TASKS)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_raddr (r_cmp_idx),
        .o_rdata (data_rdata_raw)
    );

    assign data_rdata = t_entry'(data_rdata_raw);

    // One read in flight: when the issue index reaches the fill count, the last compare is now
    assign hit  = r_cmp_v && (key_rdata == r_item.task_key);
    assign miss = (r_rd_idx == r_used) && !hit;
    assign full = (r_used == CNT_W'(MAX_TASKS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_cmp_v     <= n_cmp_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_slot    <= n_slot;
        r_item    <= n_item;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_rd_idx    = r_rd_idx;
        n_cmp_v     = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_slot      = r_slot;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;

        key_we      = 1'b0;
        key_waddr   = r_used[IDX_W-1:0];
        key_wdata   = r_item.task_key;
        data_we     = 1'b0;
        data_waddr  = r_used[IDX_W-1:0];
        data_wdata  = '{total_time: {32'd0, r_item.run_time},
                        run_count:  32'd1,
                        stack_peak: r_item.stack_high_mark};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item   = i_in_data;
                    n_rd_idx = '0;
                    n_res    = '{status: ST_OK, total_time: '0, run_count: '0, stack_peak: '0};
                    if (i_in_data.command == CMD_RECORD || i_in_data.command == CMD_GET) begin
                        n_state = S_SEARCH;
                    end else begin
                        if (i_in_data.command == CMD_CLEAR) begin
                            n_used = '0;
                        end
                        n_state = S_RESPOND;
                    end
                end
            end

            S_SEARCH: begin
                if (hit) begin
                    // data RAM reads r_cmp_idx this cycle
                    n_slot  = r_cmp_idx;
                    n_state = S_UPDATE;
                end else if (miss) begin
                    if (r_item.command == CMD_GET) begin
                        n_res.status = ST_NOT_FOUND;
                    end else if (full) begin
                        n_res.status = ST_FULL;
                    end else begin
                        key_we  = 1'b1;
                        data_we = 1'b1;
                        n_used  = r_used + CNT_W'(1);
                    end
                    n_state = S_RESPOND;
                end else begin
                    if (r_rd_idx != r_used) begin
                        n_cmp_v   = 1'b1;
                        n_cmp_idx = r_rd_idx[IDX_W-1:0];
                        n_rd_idx  = r_rd_idx + CNT_W'(1);
                    end
                end
            end

            S_UPDATE: begin
                if (r_item.command == CMD_GET) begin
                    n_res.total_time = data_rdata.total_time;
                    n_res.run_count  = data_rdata.run_count;
                    n_res.stack_peak = data_rdata.stack_peak;
                end else begin
                    data_we                = 1'b1;
                    data_waddr             = r_slot;
                    data_wdata.total_time  = data_rdata.total_time + {32'd0, r_item.run_time};
                    data_wdata.run_count   = data_rdata.run_count + 32'd1;
                    data_wdata.stack_peak  = (r_item.stack_high_mark > data_rdata.stack_peak)
                                           ? r_item.stack_high_mark : data_rdata.stack_peak;
                end
                n_state = S_RESPOND;
            end

            S_RESPOND: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TMT_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CNT_W'(MAX_TASKS))
    `TMT_ASSERT_NEXT(a_append_grows, i_clk, i_rst_n, r_state == S_SEARCH && miss && !full && r_item.command == CMD_RECORD, r_used == $past(r_used) + CNT_W'(1))
    `TMT_ASSERT_IMP(a_cmp_in_range, i_clk, i_rst_n, r_state == S_SEARCH && r_cmp_v, {1'b0, r_cmp_idx} < {1'b0, r_used})
    `TMT_ASSERT_NEXT(a_load_from_respond, i_clk, i_rst_n, r_state != S_RESPOND && !r_out_valid, !r_out_valid)

endmodule

>>> hdl/tmt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module tmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> test/task_metric_table_tb.sv
// Self-checking testbench for task_metric_table: directed and random record/get/clear traffic.
// A scoreboard class predicts every result from its own copy of the table; depends on tmt_pkg.
module task_metric_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmt_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 850;
    localparam int KEY_POOL_SIZE = 20;      // more keys than slots, so the table fills
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD_AT = 300;      // results seen before the long receiver hold
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PAUSE_AT = 450;          // random item before which the sender drains

    class metric_scoreboard;
        logic [31:0] key_tab[MAX_TASKS];
        logic [63:0] time_tab[MAX_TASKS];
        logic [31:0] count_tab[MAX_TASKS];
        logic [31:0] peak_tab[MAX_TASKS];
        int unsigned used;
        t_out_item expected_q[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned n_hits;
        int unsigned n_appends;
        int unsigned n_full;
        int unsigned n_get_found;
        int unsigned n_get_miss;
        int unsigned n_clears;
        int unsigned n_unused;

        function new();
            wipe();
            mismatches = 0;
            checked = 0;
            n_hits = 0;
            n_appends = 0;
            n_full = 0;
            n_get_found = 0;
            n_get_miss = 0;
            n_clears = 0;
            n_unused = 0;
        endfunction

        function void wipe();
            used = 0;
            foreach (key_tab[i]) begin
                key_tab[i] = '0;
                time_tab[i] = '0;
                count_tab[i] = '0;
                peak_tab[i] = '0;
            end
        endfunction

        // First used slot holding the key, or -1.
        function int find_slot(logic [31:0] key);
            for (int i = 0; i < used; i++) begin
                if (key_tab[i] == key) return i;
            end
            return -1;
        endfunction

        function void note_input(t_in_item it);
            t_out_item exp;
            int slot;
            exp = '0;
            exp.status = ST_OK;
            case (it.command)
                CMD_RECORD: begin
                    slot = find_slot(it.task_key);
                    if (slot >= 0) begin
                        time_tab[slot] = time_tab[slot] + 64'(it.run_time);
                        count_tab[slot] = count_tab[slot] + 32'd1;
                        if (it.stack_high_mark > peak_tab[slot]) begin
                            peak_tab[slot] = it.stack_high_mark;
                        end
                        n_hits++;
                    end else if (used >= MAX_TASKS) begin
                        exp.status = ST_FULL;
                        n_full++;
                    end else begin
                        key_tab[used] = it.task_key;
                        time_tab[used] = 64'(it.run_time);
                        count_tab[used] = 32'd1;
                        peak_tab[used] = it.stack_high_mark;
                        used++;
                        n_appends++;
                    end
                end
                CMD_GET: begin
                    slot = find_slot(it.task_key);
                    if (slot >= 0) begin
                        exp.total_time = time_tab[slot];
                        exp.run_count = count_tab[slot];
                        exp.stack_peak = peak_tab[slot];
                        n_get_found++;
                    end else begin
                        exp.status = ST_NOT_FOUND;
                        n_get_miss++;
                    end
                end
                CMD_CLEAR: begin
                    wipe();
                    n_clears++;
                end
                default: n_unused++;
            endcase
            expected_q.push_back(exp);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (expected_q.size() == 0) begin
                $error("result transaction with nothing outstanding: %h", got);
                mismatches++;
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                mismatches++;
            end
            if (got.total_time !== exp.total_time) begin
                $error("total_time: expected %0d, got %0d", exp.total_time, got.total_time);
                mismatches++;
            end
            if (got.run_count !== exp.run_count) begin
                $error("run_count: expected %0d, got %0d", exp.run_count, got.run_count);
                mismatches++;
            end
            if (got.stack_peak !== exp.stack_peak) begin
                $error("stack_peak: expected %0d, got %0d", exp.stack_peak, got.stack_peak);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_data;

    metric_scoreboard board;
    logic [31:0] key_pool[KEY_POOL_SIZE];
    int send_calm_left;
    int cycle_count;

    task_metric_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap(int idle_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r >= idle_pct) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    function automatic t_in_item make_item(logic [1:0] cmd, logic [31:0] key,
                                           logic [31:0] rt, logic [31:0] pk);
        t_in_item it;
        it.command = cmd;
        it.task_key = key;
        it.run_time = rt;
        it.stack_high_mark = pk;
        return it;
    endfunction

    function automatic logic [31:0] draw_value();
        if ($urandom_range(0, 99) < 70) return $urandom_range(0, 5000);
        return $urandom();
    endfunction

    function automatic void refill_key_pool();
        foreach (key_pool[i]) key_pool[i] = $urandom();
    endfunction

    // Well-formed traffic on a pool of live keys, with some misses, clears and junk commands.
    function automatic t_in_item make_random_item();
        int r;
        logic [31:0] key;
        r = $urandom_range(0, 99);
        key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        if (r < 55) return make_item(CMD_RECORD, key, draw_value(), draw_value());
        if (r < 83) return make_item(CMD_GET, key, $urandom(), $urandom());
        if (r < 88) return make_item(CMD_GET, $urandom(), $urandom(), $urandom());
        if (r < 92) return make_item(CMD_RECORD, $urandom(), draw_value(), draw_value());
        if (r < 95) begin
            if ($urandom_range(0, 3) == 0) refill_key_pool();
            return make_item(CMD_CLEAR, $urandom(), $urandom(), $urandom());
        end
        if (r < 97) return make_item(CMD_UNUSED, $urandom(), $urandom(), $urandom());
        return make_item(CMD_RECORD, key, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        if (send_calm_left > 0) begin
            send_calm_left--;
            gap = 0;
        end else begin
            gap = draw_gap(45);
            if ($urandom_range(0, 99) < 3) send_calm_left = 40;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_input(it);
    endtask

    task automatic wait_all_results();
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_item(make_item(CMD_GET, 32'h0, 32'h0, 32'h0));
        send_item(make_item(CMD_RECORD, 32'h0, 32'hFFFF_FFFF, 32'h0));
        send_item(make_item(CMD_RECORD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(CMD_RECORD, 32'h0, 32'h0, 32'h5));
        send_item(make_item(CMD_GET, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(CMD_RECORD, 32'hFFFF_FFFF, 32'h1, 32'h1));
        send_item(make_item(CMD_GET, 32'hFFFF_FFFF, 32'h0, 32'h0));
        send_item(make_item(CMD_UNUSED, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(CMD_GET, 32'h0, 32'h0, 32'h0));
        // fill the remaining slots
        for (int i = 1; i <= MAX_TASKS - 2; i++) begin
            send_item(make_item(CMD_RECORD, 32'(i) * 32'h0101_0101, 32'(i), 32'(i)));
        end
        send_item(make_item(CMD_RECORD, 32'hDEAD_0001, 32'h7, 32'h7));
        send_item(make_item(CMD_RECORD, 32'h0, 32'h2, 32'h8000_0000));
        send_item(make_item(CMD_GET, 32'h0, 32'h0, 32'h0));
        send_item(make_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(CMD_GET, 32'h0, 32'h0, 32'h0));
    endtask

    initial begin : result_sink
        int stall_left;
        int hold_left;
        int calm_left;
        bit held;
        stall_left = 0;
        hold_left = 0;
        calm_left = 0;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) board.check_result(o_out_data);
            // one long hold so the block backs up and stalls its input
            if (!held && board.checked >= LONG_HOLD_AT) begin
                held = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    stall_left = draw_gap(30);
                    if ($urandom_range(0, 99) < 2) calm_left = 100;
                end
            end
        end
    end

    initial begin : stimulus
        board = new();
        cycle_count = 0;
        send_calm_left = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        refill_key_pool();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PAUSE_AT) begin
                // drop valid so the last transaction is not offered again
                i_in_valid <= 1'b0;
                wait_all_results();
            end
            send_item(make_random_item());
        end
        i_in_valid <= 1'b0;

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d record hits, %0d appends, %0d table-full records,",
                 board.checked, board.n_hits, board.n_appends, board.n_full);
        $display("%0d found gets, %0d missed gets, %0d clears, %0d unused commands.",
                 board.n_get_found, board.n_get_miss, board.n_clears, board.n_unused);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
